// ===== rtl/luma_conv3x3_filter_top_macros.svh =====
// Assertion macros for the luma 3x3 convolution filter.
// Included by the top level; no other dependencies.
`ifndef LUMA_CONV3X3_FILTER_TOP_MACROS_SVH
`define LUMA_CONV3X3_FILTER_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define LCF_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define LCF_ASSERT_NEXT(label, clk, rst, trig, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (prop)) else $error(msg);
`else
`define LCF_ASSERT(label, clk, rst, prop, msg)
`define LCF_ASSERT_NEXT(label, clk, rst, trig, prop, msg)
`endif
`endif

// ===== rtl/lcf_pkg.sv =====
// Shared types, constants and kernel tables of the luma 3x3 convolution filter.
// No dependencies; used by every module of the block.
package lcf_pkg;

   localparam int LUMA_W    = 8;
   localparam int WEIGHT_W  = 20;
   localparam int BIAS_W    = 25;
   localparam int PROD_W    = LUMA_W + 1 + WEIGHT_W;
   localparam int PSUM_W    = PROD_W + 2;
   localparam int ACC_W     = PSUM_W + 2;
   localparam int FRAC_BITS = 16;
   localparam int FX_ONE    = 65536;

   localparam int POS_X_W     = 11;
   localparam int POS_Y_W     = 12;
   localparam int CSR_W       = 12;
   localparam int CSR_INDEX_W = 2;
   localparam int FILTER_W    = 4;

   localparam logic [CSR_INDEX_W-1:0] CSR_FILTER_SELECT = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_WIDTH   = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_HEIGHT  = 2'd2;

   localparam logic [FILTER_W-1:0] FILTER_PASSTHROUGH = 4'd0;
   localparam logic [FILTER_W-1:0] FILTER_SEPIA       = 4'd1;
   localparam logic [FILTER_W-1:0] FILTER_EDGE        = 4'd2;
   localparam logic [FILTER_W-1:0] FILTER_SHARPEN     = 4'd3;
   localparam logic [FILTER_W-1:0] FILTER_BLUR        = 4'd4;
   localparam logic [FILTER_W-1:0] FILTER_EMBOSS      = 4'd5;
   localparam logic [FILTER_W-1:0] FILTER_GRAY        = 4'd6;
   localparam logic [FILTER_W-1:0] FILTER_ENHANCE     = 4'd7;
   localparam logic [FILTER_W-1:0] FILTER_NEGATIVE    = 4'd8;
   localparam logic [FILTER_W-1:0] NUM_KERNELS        = 4'd9;

   localparam logic [FILTER_W-1:0] FILTER_SELECT_RESET = FILTER_PASSTHROUGH;
   localparam logic [CSR_W-1:0]    FRAME_WIDTH_RESET   = 12'd640;
   localparam logic [CSR_W-1:0]    FRAME_HEIGHT_RESET  = 12'd480;
   localparam logic [CSR_W-1:0]    MIN_FRAME_SIZE      = 12'd3;

   localparam logic [15:0] LUMA_R_COEF = 16'd77;
   localparam logic [15:0] LUMA_G_COEF = 16'd150;
   localparam logic [15:0] LUMA_B_COEF = 16'd29;

   localparam int QUEUE_DEPTH = 8;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [WEIGHT_W-1:0] FX_P1 = WEIGHT_W'(FX_ONE);
   localparam logic [WEIGHT_W-1:0] FX_P2 = WEIGHT_W'(2 * FX_ONE);
   localparam logic [WEIGHT_W-1:0] FX_P5 = WEIGHT_W'(5 * FX_ONE);
   localparam logic [WEIGHT_W-1:0] FX_P6 = WEIGHT_W'(6 * FX_ONE);
   localparam logic [WEIGHT_W-1:0] FX_M1 = WEIGHT_W'(-1 * FX_ONE);
   localparam logic [WEIGHT_W-1:0] FX_M2 = WEIGHT_W'(-2 * FX_ONE);
   localparam logic [WEIGHT_W-1:0] FX_M4 = WEIGHT_W'(-4 * FX_ONE);
   localparam logic [WEIGHT_W-1:0] FX_0  = '0;

   typedef logic [LUMA_W-1:0]                 luma_type;
   // [0] line two above, [1] line above, [2] current line
   typedef logic [2:0][LUMA_W-1:0]            col_type;
   typedef logic [2:0][WEIGHT_W-1:0]          col_weight_type;
   typedef logic [8:0][WEIGHT_W-1:0]          kernel_taps_type;
   typedef logic signed [PSUM_W-1:0]          psum_type;
   typedef logic signed [BIAS_W-1:0]          bias_type;

   typedef struct packed {
      logic [7:0]         red;
      logic [7:0]         green;
      logic [7:0]         blue;
      logic [POS_X_W-1:0] pos_x;
      logic [POS_Y_W-1:0] pos_y;
      logic               has_gray;
      logic               has_pixel;
   } pix_info_type;

   typedef struct packed {
      logic [7:0]   gray;
      pix_info_type info;
   } queue_entry_type;

   typedef struct packed {
      logic [7:0]         red;
      logic [7:0]         green;
      logic [7:0]         blue;
      logic [POS_X_W-1:0] pos_x;
      logic [POS_Y_W-1:0] pos_y;
      logic               last;
   } result_type;

   // Taps in raster order of the window, tap 0 top left; packed so [8] comes first.
   function automatic kernel_taps_type kernel_taps(input logic [FILTER_W-1:0] sel);
      kernel_taps_type t;
      t = '0;
      unique case (sel)
         FILTER_SEPIA: begin
            t = {20'd8585, 20'd34996, 20'd17826, 20'd11010, 20'd44957,
                 20'd22872, 20'd12386, 20'd50397, 20'd25750};
         end
         FILTER_EDGE: begin
            t = {FX_0, FX_P1, FX_0, FX_P1, FX_M4, FX_P1, FX_0, FX_P1, FX_0};
         end
         FILTER_SHARPEN: begin
            t = {FX_0, FX_M1, FX_0, FX_M1, FX_P5, FX_M1, FX_0, FX_M1, FX_0};
         end
         FILTER_BLUR: begin
            t = {20'd4096, 20'd8192, 20'd4096, 20'd8192, 20'd16384,
                 20'd8192, 20'd4096, 20'd8192, 20'd4096};
         end
         FILTER_EMBOSS: begin
            t = {FX_P2, FX_P1, FX_0, FX_P1, FX_P1, FX_M1, FX_0, FX_M1, FX_M2};
         end
         FILTER_GRAY: begin
            t = {20'd4732, 20'd46871, 20'd13933, 20'd4732, 20'd46871,
                 20'd13933, 20'd4732, 20'd46871, 20'd13933};
         end
         FILTER_ENHANCE: begin
            t = {FX_0, FX_M1, FX_0, FX_M1, FX_P6, FX_M1, FX_0, FX_M1, FX_0};
         end
         FILTER_NEGATIVE: begin
            t = {FX_M1, FX_0, FX_0, FX_0, FX_M1, FX_0, FX_0, FX_0, FX_M1};
         end
         default: begin
            t = '0;
         end
      endcase
      return t;
   endfunction

   function automatic bias_type kernel_bias(input logic [FILTER_W-1:0] sel);
      bias_type b;
      b = '0;
      unique case (sel)
         FILTER_EMBOSS:   b = BIAS_W'(128 * FX_ONE);
         FILTER_NEGATIVE: b = BIAS_W'(255 * FX_ONE);
         default:         b = '0;
      endcase
      return b;
   endfunction

endpackage

// ===== rtl/lcf_win_cell.sv =====
// One column cell of the 3x3 luma window: holds three luma values, passes them
// to its left neighbor and forms the registered weighted column sum. Uses lcf_pkg.
module lcf_win_cell (
   input  logic                    clock,
   input  logic                    shift_en,
   input  lcf_pkg::col_type        load_col,
   input  lcf_pkg::col_weight_type weights,
   output lcf_pkg::col_type        col_out,
   output lcf_pkg::psum_type       psum_out
);

   lcf_pkg::col_type  col_ff;
   lcf_pkg::col_type  col_in;
   lcf_pkg::psum_type psum_ff;
   lcf_pkg::psum_type psum_in;
   logic signed [lcf_pkg::PROD_W-1:0] prod [3];

   always_comb begin
      col_in  = shift_en ? load_col : col_ff;
      psum_in = '0;
      for (int k = 0; k < 3; k++) begin
         prod[k] = lcf_pkg::PROD_W'($signed({1'b0, col_ff[k]}))
                 * lcf_pkg::PROD_W'($signed(weights[k]));
         psum_in = psum_in + lcf_pkg::PSUM_W'(prod[k]);
      end
   end

   always_ff @(posedge clock) begin
      col_ff  <= col_in;
      psum_ff <= psum_in;
   end

   assign col_out  = col_ff;
   assign psum_out = psum_ff;

endmodule

// ===== rtl/lcf_out_queue.sv =====
// Result queue: each entry holds the one or two results caused by one pixel and
// hands them out one beat at a time. Uses lcf_pkg.
module lcf_out_queue (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push_valid,
   input  lcf_pkg::queue_entry_type     push_entry,
   input  logic                         pop_ready,
   output logic                         pop_valid,
   output lcf_pkg::result_type          pop_result,
   output logic [lcf_pkg::QCNT_W-1:0]   level
);

   lcf_pkg::queue_entry_type queue_ff [lcf_pkg::QUEUE_DEPTH];

   logic [lcf_pkg::QPTR_W-1:0] head_ff, head_in;
   logic [lcf_pkg::QPTR_W-1:0] tail_ff, tail_in;
   logic [lcf_pkg::QCNT_W-1:0] count_ff, count_in;
   logic                       half_ff, half_in;

   lcf_pkg::queue_entry_type head_entry;
   logic                     show_gray;
   logic                     pop_beat;
   logic                     entry_done;

   always_comb begin
      head_entry = queue_ff[head_ff];
      show_gray  = head_entry.info.has_gray && !half_ff;
      pop_valid  = (count_ff != '0);

      pop_result.pos_x = show_gray ? head_entry.info.pos_x - 11'd1 : head_entry.info.pos_x;
      pop_result.pos_y = show_gray ? head_entry.info.pos_y - 12'd1 : head_entry.info.pos_y;
      pop_result.red   = show_gray ? head_entry.gray : head_entry.info.red;
      pop_result.green = show_gray ? head_entry.gray : head_entry.info.green;
      pop_result.blue  = show_gray ? head_entry.gray : head_entry.info.blue;
      pop_result.last  = show_gray ? !head_entry.info.has_pixel : 1'b1;

      pop_beat   = pop_valid && pop_ready;
      entry_done = pop_beat && pop_result.last;

      // depth is a power of two, so the pointers wrap on their own
      head_in  = entry_done ? head_ff + lcf_pkg::QPTR_W'(1) : head_ff;
      tail_in  = push_valid ? tail_ff + lcf_pkg::QPTR_W'(1) : tail_ff;
      count_in = count_ff + lcf_pkg::QCNT_W'(push_valid) - lcf_pkg::QCNT_W'(entry_done);

      half_in = half_ff;
      if (entry_done) begin
         half_in = 1'b0;
      end else if (pop_beat) begin
         half_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
         half_ff  <= 1'b0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
         half_ff  <= half_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         queue_ff[tail_ff] <= push_entry;
      end
   end

   assign level = count_ff;

endmodule

// ===== rtl/luma_conv3x3_filter_top.sv =====
// Luma 3x3 convolution filter, top level: position counters, line store,
// window cell chain, kernel sum and result queue. Uses lcf_pkg, lcf_win_cell,
// lcf_out_queue and luma_conv3x3_filter_top_macros.svh.
//
// Usage: RGB24 pixels enter on the req_ channel in raster order, one beat per
// pixel, req_frame_start marking the first pixel of a frame. Each pixel is
// turned to luma; the window completed by it yields a gray result for the
// pixel one up and one left, and a border pixel is also sent back unchanged
// with its coordinates. A pixel thus gives zero, one or two rsp_ beats;
// rsp_last_of_run marks the last one. With filter 0 every pixel comes back as is.
// Results pass the s1, s2 and s3 stage registers and then the result queue on their way to rsp_.
// Throughput: one pixel per cycle while req_ready is high; a pixel with two results holds the output
// for two rsp_ beats, and the eight-entry result queue absorbs that.
// When rsp_ready stays low the queue fills and req_ready drops once the queue
// plus the three-stage pipeline could no longer take another pixel's results.
// The csr_ port sets filter, width and height; write it only while idle.
// Reset (synchronous) empties the pipeline and queue, homes the counters to
// (0,0) and loads filter 0 and a 640x480 frame. The line store needs no
// clearing pass: every line is written before the window reads it.
`include "luma_conv3x3_filter_top_macros.svh"
module luma_conv3x3_filter_top #(
   parameter int MAX_LINE_PIXELS = 2048
) (
   input  logic                              clock,
   input  logic                              reset,

   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [7:0]                        req_red_in,
   input  logic [7:0]                        req_green_in,
   input  logic [7:0]                        req_blue_in,
   input  logic                              req_frame_start,

   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [7:0]                        rsp_red_out,
   output logic [7:0]                        rsp_green_out,
   output logic [7:0]                        rsp_blue_out,
   output logic [lcf_pkg::POS_X_W-1:0]       rsp_pos_x,
   output logic [lcf_pkg::POS_Y_W-1:0]       rsp_pos_y,
   output logic                              rsp_last_of_run,

   input  logic                              csr_write_en,
   input  logic [lcf_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [lcf_pkg::CSR_W-1:0]         csr_wdata
);

   localparam int CW = $clog2(MAX_LINE_PIXELS);
   localparam int WW = $clog2(MAX_LINE_PIXELS + 1);
   localparam int YW = lcf_pkg::POS_Y_W;

   // configuration
   logic [lcf_pkg::FILTER_W-1:0] filter_sel_ff;
   logic [lcf_pkg::CSR_W-1:0]    frame_width_ff;
   logic [lcf_pkg::CSR_W-1:0]    frame_height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         filter_sel_ff   <= lcf_pkg::FILTER_SELECT_RESET;
         frame_width_ff  <= lcf_pkg::FRAME_WIDTH_RESET;
         frame_height_ff <= lcf_pkg::FRAME_HEIGHT_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index)
            lcf_pkg::CSR_FILTER_SELECT: filter_sel_ff <= csr_wdata[lcf_pkg::FILTER_W-1:0];
            lcf_pkg::CSR_FRAME_WIDTH:   frame_width_ff  <= csr_wdata;
            lcf_pkg::CSR_FRAME_HEIGHT:  frame_height_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // frame size in use
   logic [12:0]   width_wide;
   logic [WW-1:0] width_use;
   logic [YW-1:0] height_use;
   logic          passthrough;

   always_comb begin
      width_wide = {1'b0, frame_width_ff};
      if (width_wide < {1'b0, lcf_pkg::MIN_FRAME_SIZE}) begin
         width_wide = {1'b0, lcf_pkg::MIN_FRAME_SIZE};
      end else if (width_wide > 13'(MAX_LINE_PIXELS)) begin
         width_wide = 13'(MAX_LINE_PIXELS);
      end
      width_use  = WW'(width_wide);
      height_use = (frame_height_ff < lcf_pkg::MIN_FRAME_SIZE) ?
                   lcf_pkg::MIN_FRAME_SIZE : frame_height_ff;
      passthrough = (filter_sel_ff == lcf_pkg::FILTER_PASSTHROUGH) ||
                    (filter_sel_ff >= lcf_pkg::NUM_KERNELS);
   end

   // stage 0: position, luma, line store read
   logic [CW-1:0] col_ff, col_in;
   logic [YW-1:0] row_ff, row_in;
   logic [CW-1:0] cur_col;
   logic [YW-1:0] cur_row;
   logic [WW-1:0] col_next;
   logic [YW-1:0] row_next;
   logic [15:0]   luma_sum;
   logic          req_beat;
   lcf_pkg::pix_info_type cur_info;

   logic s1_valid_ff, s2_valid_ff, s3_valid_ff;
   logic [lcf_pkg::QCNT_W-1:0] queue_level;
   logic [1:0]                 inflight;
   logic [lcf_pkg::QCNT_W:0]   room_need;

   always_comb begin
      inflight  = {1'b0, s1_valid_ff} + {1'b0, s2_valid_ff} + {1'b0, s3_valid_ff};
      room_need = (lcf_pkg::QCNT_W + 1)'(queue_level) + (lcf_pkg::QCNT_W + 1)'(inflight)
                + (lcf_pkg::QCNT_W + 1)'(1);
      req_ready = (room_need <= (lcf_pkg::QCNT_W + 1)'(lcf_pkg::QUEUE_DEPTH));
      req_beat  = req_valid && req_ready;
   end

   always_comb begin
      cur_col = col_ff;
      cur_row = row_ff;
      if (req_frame_start) begin
         cur_col = '0;
         cur_row = '0;
      end else begin
         // size shrank under the counters: go to the next row
         if (WW'(col_ff) >= width_use) begin
            cur_col = '0;
            cur_row = row_ff + YW'(1);
         end
         if (cur_row >= height_use) begin
            cur_row = '0;
         end
      end

      col_next = WW'(cur_col) + WW'(1);
      row_next = cur_row + YW'(1);
      if (col_next >= width_use) begin
         col_in = '0;
         row_in = (row_next >= height_use) ? '0 : row_next;
      end else begin
         col_in = CW'(col_next);
         row_in = cur_row;
      end

      luma_sum = lcf_pkg::LUMA_R_COEF * 16'(req_red_in)
               + lcf_pkg::LUMA_G_COEF * 16'(req_green_in)
               + lcf_pkg::LUMA_B_COEF * 16'(req_blue_in);

      cur_info.red       = req_red_in;
      cur_info.green     = req_green_in;
      cur_info.blue      = req_blue_in;
      cur_info.pos_x     = lcf_pkg::POS_X_W'(cur_col);
      cur_info.pos_y     = cur_row;
      cur_info.has_gray  = !passthrough && (cur_col >= CW'(2)) && (cur_row >= YW'(2));
      cur_info.has_pixel = passthrough || (cur_col == '0) || (cur_row == '0) ||
                           (WW'(cur_col) == width_use - WW'(1)) ||
                           (cur_row == height_use - YW'(1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (req_beat) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // stage 1: line store update, window shift
   lcf_pkg::pix_info_type s1_info_ff, s2_info_ff, s3_info_ff;
   logic [CW-1:0]         s1_col_ff;
   lcf_pkg::luma_type     s1_luma_ff;

   // entry: {two lines above, line above}
   logic [15:0] line_mem [MAX_LINE_PIXELS];
   logic [15:0] line_rd_ff;
   logic [15:0] fwd_data_ff;
   logic        fwd_hit_ff;
   logic [15:0] line_old;
   logic [15:0] line_wr;

   always_comb begin
      // a frame start right after a column-0 pixel hits the same column: take the pending write
      line_old = fwd_hit_ff ? fwd_data_ff : line_rd_ff;
      line_wr  = {line_old[7:0], s1_luma_ff};
   end

   always_ff @(posedge clock) begin
      line_rd_ff  <= line_mem[cur_col];
      fwd_hit_ff  <= s1_valid_ff && (s1_col_ff == cur_col);
      fwd_data_ff <= line_wr;
      if (s1_valid_ff) begin
         line_mem[s1_col_ff] <= line_wr;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= req_beat;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_info_ff <= cur_info;
      s1_col_ff  <= cur_col;
      s1_luma_ff <= luma_sum[15:8];
      s2_info_ff <= s1_info_ff;
      s3_info_ff <= s2_info_ff;
   end

   // window cell chain: cell 2 takes the new column, cell 0 holds the oldest
   lcf_pkg::kernel_taps_type taps;
   lcf_pkg::col_type         cell_load [3];
   lcf_pkg::col_type         cell_col  [3];
   lcf_pkg::col_weight_type  cell_w    [3];
   lcf_pkg::psum_type        cell_psum [3];

   always_comb begin
      taps = lcf_pkg::kernel_taps(filter_sel_ff);
      cell_load[2] = {s1_luma_ff, line_old[7:0], line_old[15:8]};
      cell_load[1] = cell_col[2];
      cell_load[0] = cell_col[1];
      for (int j = 0; j < 3; j++) begin
         cell_w[j] = {taps[6 + j], taps[3 + j], taps[j]};
      end
   end

   for (genvar j = 0; j < 3; j++) begin : g_cell
      lcf_win_cell u_cell (
         .clock    (clock),
         .shift_en (s1_valid_ff),
         .load_col (cell_load[j]),
         .weights  (cell_w[j]),
         .col_out  (cell_col[j]),
         .psum_out (cell_psum[j])
      );
   end

   // stage 3: kernel sum, bias, shift and clamp
   logic signed [lcf_pkg::ACC_W-1:0] acc;
   logic [7:0]                       gray;
   lcf_pkg::queue_entry_type         push_entry;
   logic                             queue_push;
   lcf_pkg::result_type              result;

   always_comb begin
      acc = lcf_pkg::ACC_W'(lcf_pkg::kernel_bias(filter_sel_ff))
          + lcf_pkg::ACC_W'(cell_psum[0])
          + lcf_pkg::ACC_W'(cell_psum[1])
          + lcf_pkg::ACC_W'(cell_psum[2]);
      if (acc[lcf_pkg::ACC_W-1]) begin
         gray = 8'd0;
      end else if (|acc[lcf_pkg::ACC_W-2:lcf_pkg::FRAC_BITS+lcf_pkg::LUMA_W]) begin
         gray = 8'd255;
      end else begin
         gray = acc[lcf_pkg::FRAC_BITS+lcf_pkg::LUMA_W-1:lcf_pkg::FRAC_BITS];
      end
      push_entry.gray = gray;
      push_entry.info = s3_info_ff;
      // drop pixels that cause no result
      queue_push = s3_valid_ff && (s3_info_ff.has_gray || s3_info_ff.has_pixel);
   end

   lcf_out_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (queue_push),
      .push_entry (push_entry),
      .pop_ready  (rsp_ready),
      .pop_valid  (rsp_valid),
      .pop_result (result),
      .level      (queue_level)
   );

   assign rsp_red_out     = result.red;
   assign rsp_green_out   = result.green;
   assign rsp_blue_out    = result.blue;
   assign rsp_pos_x       = result.pos_x;
   assign rsp_pos_y       = result.pos_y;
   assign rsp_last_of_run = result.last;

   `LCF_ASSERT(a_no_push_when_full, clock, reset, queue_push |-> (queue_level < lcf_pkg::QCNT_W'(lcf_pkg::QUEUE_DEPTH)), "result queue overflow")
   `LCF_ASSERT_NEXT(a_beat_enters_pipe, clock, reset, req_beat, s1_valid_ff, "accepted pixel lost")
   `LCF_ASSERT_NEXT(a_run_completes, clock, reset, rsp_valid && rsp_ready && !rsp_last_of_run, rsp_valid && rsp_last_of_run, "second result of a run missing")

endmodule
